FILE: sv/sbmf_pkg.sv
// Package for the separable box minimum filter: sizes, codes, types and the min tree.
`default_nettype none

package sbmf_pkg;

    // Geometry limits
    localparam int MAX_RADIUS   = 7;
    localparam int MAX_WIDTH    = 1024;
    localparam int PIXEL_BITS   = 16;
    localparam int HEIGHT_LIMIT = 4096;

    // Derived sizes
    localparam int TAPS          = 2 * MAX_RADIUS + 1;
    localparam int LINES         = 2 * MAX_RADIUS;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int ROW_BITS      = $clog2(HEIGHT_LIMIT);
    localparam int SPAN_BITS     = $clog2(LINES + 1);
    localparam int SLOT_BITS     = $clog2(LINES);
    localparam int TREE_SIZE     = 1 << $clog2(TAPS);
    localparam int MOD_BIT_BITS  = $clog2(ROW_BITS);

    // Register field widths
    localparam int RADIUS_BITS    = 3;
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = HEIGHT_BITS;

    typedef logic [PIXEL_BITS-1:0]                  t_pix;
    typedef logic [TREE_SIZE-1:0][PIXEL_BITS-1:0]   t_tree;
    typedef logic [CFG_INDEX_BITS-1:0]              t_cfg_index;

    localparam t_pix PIX_ONES = '1;

    // Register indexes
    localparam t_cfg_index CFG_RADIUS = 2'd0;
    localparam t_cfg_index CFG_WIDTH  = 2'd1;
    localparam t_cfg_index CFG_HEIGHT = 2'd2;

    // Register reset values and caps
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 3'd1;
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd1024;
    localparam logic [WIDTH_BITS-1:0]  WIDTH_CAP    = WIDTH_BITS'(MAX_WIDTH);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_CAP   = HEIGHT_BITS'(HEIGHT_LIMIT);

    // Stage-one control word
    typedef struct packed {
        logic                 valid;
        logic                 emit;
        logic                 row_last;
        logic                 frame_last;
        logic [COL_BITS-1:0]  col;
        logic [SLOT_BITS-1:0] slot;
    } t_s1;

    // Balanced minimum over a power-of-two set of pixels, one level per pass
    function automatic t_pix min_tree(input t_tree v_in);
        t_tree v;
        v = v_in;
        for (int s = TREE_SIZE / 2; s > 0; s = s >> 1) begin
            for (int j = 0; j < s; j++) begin
                v[j] = (v[2*j+1] < v[2*j]) ? v[2*j+1] : v[2*j];
            end
        end
        return v[0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/sbmf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sbmf_ram #(
    parameter int  WIDTH     = 16,
    parameter int  DEPTH     = 1024,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic                 i_re,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds its word while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/separable_box_min_filter.sv
// Top level of the separable (2r+1)x(2r+1) box minimum filter (dark channel minimum).
`default_nettype none

// Takes one padded pixel per clock in raster order and gives one result per
// clock once the window is full: a result for each pixel whose column and row
// are both at least 2r, flagged with row_last and frame_last. An accepted
// pixel passes the stage-one register into the output register; the input is
// stalled while the output register and the stage before it are both held.
// Row minima of the last 2r rows sit in 14 line RAMs of 1024 x 16. All are
// read and the one of the row's slot is written per pixel, which sets the
// one-pixel-per-clock rate. A write of the radius register starts a bit-serial
// pass that recomputes the line slot as row modulo 2r; the input is stalled during it.
// Line RAM contents are not cleared by reset; with the dimensions above 2r
// no unwritten entry is ever used. Configure only while the block is idle.
module separable_box_min_filter
    import sbmf_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // pixel input
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [PIXEL_BITS-1:0]    i_pixel,
    // result output
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic      [PIXEL_BITS-1:0]    o_dark_value,
    output logic                          o_row_last,
    output logic                          o_frame_last,
    // register write
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // Configuration registers
    logic [RADIUS_BITS-1:0] r_radius;
    logic [WIDTH_BITS-1:0]  r_pwidth;
    logic [HEIGHT_BITS-1:0] r_pheight;

    // Position state
    logic [COL_BITS-1:0]  r_col;
    logic [ROW_BITS-1:0]  r_row;
    logic [SLOT_BITS-1:0] r_slot;

    // Slot recompute
    logic                    r_mod_busy;
    logic [MOD_BIT_BITS-1:0] r_mod_bit;
    logic [SPAN_BITS-1:0]    r_mod_rem;

    // Horizontal window, taps 0 to TAPS-2 of the current window
    t_pix r_win [TAPS-1];

    // Pipeline
    t_s1  r_s1;
    t_pix r_s1_hmin;
    logic r_out_valid;
    t_pix r_out_value;
    logic r_out_rl;
    logic r_out_fl;

    // Combinational
    logic [WIDTH_BITS-1:0]  w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic [WIDTH_BITS-1:0]  w_m1;
    logic [HEIGHT_BITS-1:0] h_m1;
    logic [SPAN_BITS-1:0]   span;
    logic                   accept;
    logic                   out_free;
    logic                   s1_adv;
    logic                   col_wrap;
    logic                   row_wrap;
    logic [SLOT_BITS-1:0]   n_slot_inc;
    t_tree                  h_tree;
    t_tree                  v_tree;
    t_pix                   n_hmin;
    t_pix                   vmin;
    t_pix                   rd [LINES];
    logic [SPAN_BITS:0]     mod_try;
    logic [SPAN_BITS:0]     mod_next;
    t_s1                    n_s1;

    // Effective dimensions
    always_comb begin
        if (r_pwidth == '0) begin
            w_eff = WIDTH_BITS'(1);
        end else if (r_pwidth > WIDTH_CAP) begin
            w_eff = WIDTH_CAP;
        end else begin
            w_eff = r_pwidth;
        end
        if (r_pheight == '0) begin
            h_eff = HEIGHT_BITS'(1);
        end else if (r_pheight > HEIGHT_CAP) begin
            h_eff = HEIGHT_CAP;
        end else begin
            h_eff = r_pheight;
        end
        w_m1 = w_eff - WIDTH_BITS'(1);
        h_m1 = h_eff - HEIGHT_BITS'(1);
        span = SPAN_BITS'({r_radius, 1'b0});
    end

    // Handshake
    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_adv      = r_s1.valid && (!r_s1.emit || out_free);
    assign o_in_stall  = r_mod_busy || (r_s1.valid && !s1_adv);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Position decode
    assign col_wrap = ({1'b0, r_col} >= w_m1);
    assign row_wrap = ({1'b0, r_row} >= h_m1);

    always_comb begin
        if (span == '0 || (SPAN_BITS'(r_slot) + SPAN_BITS'(1)) == span) begin
            n_slot_inc = '0;
        end else begin
            n_slot_inc = r_slot + SLOT_BITS'(1);
        end
    end

    // Horizontal minimum over the window including the new pixel
    always_comb begin
        h_tree    = '1;
        h_tree[0] = i_pixel;
        for (int i = 1; i < TAPS; i++) begin
            if (SPAN_BITS'(i) <= span) begin
                h_tree[i] = r_win[i-1];
            end
        end
        n_hmin = min_tree(h_tree);
    end

    // Stage-one control for the accepted pixel
    always_comb begin
        n_s1.valid      = accept;
        n_s1.emit       = ({1'b0, r_col} >= (COL_BITS+1)'(span))
                          && ({1'b0, r_row} >= (ROW_BITS+1)'(span));
        n_s1.row_last   = ({1'b0, r_col} == w_m1);
        n_s1.frame_last = ({1'b0, r_col} == w_m1) && ({1'b0, r_row} == h_m1);
        n_s1.col        = r_col;
        n_s1.slot       = r_slot;
    end

    // Line RAMs of row minima
    for (genvar g = 0; g < LINES; g++) begin : g_line
        sbmf_ram #(
            .WIDTH (PIXEL_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (s1_adv && (span != '0) && (r_s1.slot == SLOT_BITS'(g))),
            .i_waddr (r_s1.col),
            .i_wdata (r_s1_hmin),
            .i_re    (accept),
            .i_raddr (r_col),
            .o_rdata (rd[g])
        );
    end

    // Vertical minimum across stored row minima
    always_comb begin
        v_tree    = '1;
        v_tree[0] = r_s1_hmin;
        for (int i = 0; i < LINES; i++) begin
            if (SPAN_BITS'(i) < span) begin
                v_tree[i+1] = rd[i];
            end
        end
        vmin = min_tree(v_tree);
    end

    // Slot recompute step: restoring remainder, one row bit per clock while no register is written
    always_comb begin
        mod_try = {r_mod_rem, r_row[r_mod_bit]};
        if (mod_try >= {1'b0, span}) begin
            mod_next = mod_try - {1'b0, span};
        end else begin
            mod_next = mod_try;
        end
    end

    // Configuration, counters and slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= RADIUS_RESET;
            r_pwidth   <= WIDTH_RESET;
            r_pheight  <= HEIGHT_RESET;
            r_col      <= '0;
            r_row      <= '0;
            r_slot     <= '0;
            r_mod_busy <= 1'b0;
            r_mod_bit  <= '0;
            r_mod_rem  <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RADIUS: begin
                        r_radius   <= i_cfg_data[RADIUS_BITS-1:0];
                        r_mod_busy <= 1'b1;
                        r_mod_bit  <= MOD_BIT_BITS'(ROW_BITS - 1);
                        r_mod_rem  <= '0;
                    end
                    CFG_WIDTH:  r_pwidth  <= i_cfg_data[WIDTH_BITS-1:0];
                    CFG_HEIGHT: r_pheight <= i_cfg_data[HEIGHT_BITS-1:0];
                    default: ;
                endcase
            end else if (r_mod_busy) begin
                r_mod_rem <= mod_next[SPAN_BITS-1:0];
                if (r_mod_bit == '0) begin
                    r_mod_busy <= 1'b0;
                    r_slot     <= (span == '0) ? '0 : mod_next[SLOT_BITS-1:0];
                end else begin
                    r_mod_bit <= r_mod_bit - MOD_BIT_BITS'(1);
                end
            end
            // advance raster position
            if (accept) begin
                if (col_wrap) begin
                    r_col <= '0;
                    if (row_wrap) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= r_row + ROW_BITS'(1);
                        r_slot <= n_slot_inc;
                    end
                end else begin
                    r_col <= r_col + COL_BITS'(1);
                end
            end
        end
    end

    // Horizontal shift register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS - 1; i++) begin
                r_win[i] <= PIX_ONES;
            end
        end else if (accept) begin
            r_win[0] <= i_pixel;
            for (int i = 1; i < TAPS - 1; i++) begin
                r_win[i] <= r_win[i-1];
            end
        end
    end

    // Stage one control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (accept) begin
            r_s1 <= n_s1;
        end else if (s1_adv) begin
            r_s1.valid <= 1'b0;
        end
    end

    // Stage one data
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_hmin <= n_hmin;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_adv && r_s1.emit;
        end
    end

    // Output register word
    always_ff @(posedge i_clk) begin
        if (out_free && s1_adv && r_s1.emit) begin
            r_out_value <= vmin;
            r_out_rl    <= r_s1.row_last;
            r_out_fl    <= r_s1.frame_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_dark_value = r_out_value;
    assign o_row_last   = r_out_rl;
    assign o_frame_last = r_out_fl;

endmodule

`default_nettype wire
